FILE: design/rqs_pkg.sv
package rqs_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SELECT = 2'd1;
	localparam logic [1:0] OP_SWITCH = 2'd2;

	localparam logic [1:0] POL_FIFO = 2'd0;
	localparam logic [1:0] POL_RR   = 2'd1;
	localparam logic [1:0] POL_SPN  = 2'd2;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_INSERT,
		CMD_SEL_HEAD,
		CMD_SEL_RR,
		CMD_SEL_SPN,
		CMD_SWITCH
	} cmd_kind_t;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_PICK,
		ENG_SCAN,
		ENG_SHIFT
	} eng_state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  proc_id;
		logic [15:0] proc_remaining;
		logic [15:0] running_remaining;
		logic        running_preempted;
	} in_item_t;

	typedef struct packed {
		logic        pick_valid;
		logic [7:0]  picked_id;
		logic [15:0] picked_remaining;
		logic [1:0]  status;
		logic [4:0]  queue_count;
	} out_item_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  id;
		logic [15:0] tim;
		logic        requeue;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] tim;
	} slot_t;

endpackage

FILE: design/ready_queue_fifo_rr_spn_select.sv
// Ready-queue process selector with first-in-first-out, round-robin and shortest-process-next
// policies, chosen by a two-bit policy register. Transactions enter a two-entry command queue,
// are executed one at a time by the engine, and leave through a two-entry result queue, so each
// side may stall freely and exactly one result comes out per transaction, in order. Entries live
// in a single-port-read slot memory used as a ring. Insert, switch and a select on an empty
// queue finish in the engine's idle state; a head select under the first two policies also
// passes through the pick state. A shortest-process-next select walks the memory for the
// smallest time, then moves each entry that sits behind the chosen one up one slot to close
// the gap before it reports; the one read port of the slot memory makes both walks read one
// entry at a time. Each queue holds a transaction in a register on its way through.
module ready_queue_fifo_rr_spn_select #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  rqs_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output rqs_pkg::out_item_t result,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_data
);

	logic               cmd_valid;
	logic               cmd_ready;
	rqs_pkg::cmd_t      cmd;
	logic               res_push;
	logic               res_full;
	rqs_pkg::out_item_t res;

	rqs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd)
	);

	rqs_engine #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.res_push (res_push),
		.res_full (res_full),
		.res      (res)
	);

	rqs_res_q u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.full   (res_full),
		.wr_data(res),
		.empty  (empty),
		.rd     (pop),
		.rd_data(result)
	);

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("engine result written into a full result queue");

	a_pick_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.pick_valid) |-> (result.status == rqs_pkg::STS_OK))
		else $error("pick reported with a non-ok status");

	a_empty_sel: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status == rqs_pkg::STS_EMPTY)
			|-> (result.queue_count == 5'd0 && !result.pick_valid))
		else $error("empty-queue select with entries or a pick");

endmodule

FILE: design/rqs_ram.sv
module rqs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/rqs_front.sv
module rqs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  rqs_pkg::in_item_t item,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_data,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output rqs_pkg::cmd_t     cmd
);

	logic [1:0]    policy_q;
	rqs_pkg::cmd_t cls;
	rqs_pkg::cmd_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          do_push;
	logic          do_pop;

	// decode op and policy into an engine command
	always_comb begin
		cls.kind    = rqs_pkg::CMD_NOP;
		cls.id      = item.proc_id;
		cls.tim     = item.running_remaining;
		cls.requeue = 1'b0;
		unique case (item.op)
			rqs_pkg::OP_INSERT: begin
				cls.kind = rqs_pkg::CMD_INSERT;
				cls.tim  = item.proc_remaining;
			end
			rqs_pkg::OP_SELECT: begin
				unique case (policy_q)
					rqs_pkg::POL_RR: begin
						cls.kind    = rqs_pkg::CMD_SEL_RR;
						cls.requeue = item.running_preempted && (item.running_remaining > 16'd1);
					end
					rqs_pkg::POL_SPN: begin
						cls.kind = rqs_pkg::CMD_SEL_SPN;
					end
					default: begin
						cls.kind = rqs_pkg::CMD_SEL_HEAD;
					end
				endcase
			end
			rqs_pkg::OP_SWITCH: begin
				cls.kind    = rqs_pkg::CMD_SWITCH;
				cls.requeue = (item.running_remaining != 16'd0);
			end
			default: begin
				cls.kind = rqs_pkg::CMD_NOP;
			end
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= rqs_pkg::POL_FIFO;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (cfg_we) begin
				policy_q <= cfg_data;
			end
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

endmodule

FILE: design/rqs_res_q.sv
module rqs_res_q (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	output logic               full,
	input  rqs_pkg::out_item_t wr_data,
	output logic               empty,
	input  logic               rd,
	output rqs_pkg::out_item_t rd_data
);

	rqs_pkg::out_item_t slot_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = slot_q[rd_ptr_q];
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: design/rqs_engine.sv
module rqs_engine #(
	parameter int QUEUE_DEPTH = 16,
	localparam int AW = $clog2(QUEUE_DEPTH),
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  rqs_pkg::cmd_t      cmd,
	output logic               res_push,
	input  logic               res_full,
	output rqs_pkg::out_item_t res
);

	localparam logic [CW:0]   DEPTH_X = (CW + 1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] FULL_C  = CW'(QUEUE_DEPTH);
	localparam logic [CW-1:0] ONE     = CW'(1);
	localparam int            SLOT_W  = $bits(rqs_pkg::slot_t);

	rqs_pkg::eng_state_t state_q, state_d;
	logic [AW-1:0]       head_q, head_d;
	logic [CW-1:0]       count_q, count_d;
	logic [7:0]          run_id_q, run_id_d;
	logic                run_valid_q, run_valid_d;
	logic [CW-1:0]       rd_off_q, rd_off_d;
	logic                pend_q, pend_d;
	logic [CW-1:0]       pend_off_q, pend_off_d;
	logic [15:0]         min_time_q, min_time_d;
	logic [7:0]          min_id_q, min_id_d;
	logic [CW-1:0]       min_off_q, min_off_d;
	rqs_pkg::cmd_t       cur_q, cur_d;
	logic                upd;
	logic [CW-1:0]       best_off;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	rqs_pkg::slot_t      ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	rqs_pkg::slot_t      ram_rdata;

	// queue offset to slot address, ring wraps at the depth
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW + 1)'(base) + (CW + 1)'(off);
		if (sum >= DEPTH_X) begin
			sum = sum - DEPTH_X;
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [4:0] count5(input logic [CW-1:0] c);
		logic [CW+4:0] ext;
		ext = {5'd0, c};
		return ext[4:0];
	endfunction

	rqs_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		count_d     = count_q;
		run_id_d    = run_id_q;
		run_valid_d = run_valid_q;
		rd_off_d    = rd_off_q;
		pend_d      = pend_q;
		pend_off_d  = pend_off_q;
		min_time_d  = min_time_q;
		min_id_d    = min_id_q;
		min_off_d   = min_off_q;
		cur_d       = cur_q;
		upd         = 1'b0;
		best_off    = min_off_q;
		cmd_ready   = 1'b0;
		res_push    = 1'b0;
		res         = '0;
		ram_we      = 1'b0;
		ram_waddr   = phys(head_q, count_q);
		ram_wdata   = '{id: cmd.id, tim: cmd.tim};
		ram_re      = 1'b0;
		ram_raddr   = head_q;

		unique case (state_q)
			rqs_pkg::ENG_IDLE: begin
				if (cmd_valid && !res_full) begin
					cmd_ready = 1'b1;
					cur_d     = cmd;
					unique case (cmd.kind)
						rqs_pkg::CMD_INSERT: begin
							res_push = 1'b1;
							if (count_q == FULL_C) begin
								res.status = rqs_pkg::STS_FULL;
							end else begin
								ram_we  = 1'b1;
								count_d = count_q + ONE;
							end
						end
						rqs_pkg::CMD_SEL_HEAD, rqs_pkg::CMD_SEL_RR: begin
							if (count_q == '0) begin
								res_push   = 1'b1;
								res.status = rqs_pkg::STS_EMPTY;
							end else begin
								ram_re  = 1'b1;
								state_d = rqs_pkg::ENG_PICK;
							end
						end
						rqs_pkg::CMD_SEL_SPN: begin
							if (count_q == '0) begin
								res_push   = 1'b1;
								res.status = rqs_pkg::STS_EMPTY;
							end else begin
								rd_off_d = '0;
								pend_d   = 1'b0;
								state_d  = rqs_pkg::ENG_SCAN;
							end
						end
						rqs_pkg::CMD_SWITCH: begin
							res_push    = 1'b1;
							run_id_d    = cmd.id;
							run_valid_d = 1'b1;
							ram_wdata   = '{id: run_id_q, tim: cmd.tim};
							if (run_valid_q && cmd.requeue) begin
								if (count_q == FULL_C) begin
									res.status = rqs_pkg::STS_FULL;
								end else begin
									ram_we  = 1'b1;
									count_d = count_q + ONE;
								end
							end
						end
						default: begin
							res_push = 1'b1;
						end
					endcase
				end
			end
			rqs_pkg::ENG_PICK: begin
				res_push             = 1'b1;
				res.pick_valid       = 1'b1;
				res.picked_id        = ram_rdata.id;
				res.picked_remaining = ram_rdata.tim;
				head_d               = phys(head_q, ONE);
				// old head slot is free, so the tail write never clobbers a live entry
				if (cur_q.kind == rqs_pkg::CMD_SEL_RR && run_valid_q && cur_q.requeue) begin
					ram_we    = 1'b1;
					ram_waddr = phys(head_q, count_q);
					ram_wdata = '{id: run_id_q, tim: cur_q.tim};
				end else begin
					count_d = count_q - ONE;
				end
				state_d = rqs_pkg::ENG_IDLE;
			end
			rqs_pkg::ENG_SCAN: begin
				if (rd_off_q < count_q) begin
					ram_re     = 1'b1;
					ram_raddr  = phys(head_q, rd_off_q);
					rd_off_d   = rd_off_q + ONE;
					pend_d     = 1'b1;
					pend_off_d = rd_off_q;
				end else begin
					pend_d = 1'b0;
				end
				if (pend_q) begin
					// strict compare keeps the earliest entry on a tie
					upd = (pend_off_q == '0) || (ram_rdata.tim < min_time_q);
					if (upd) begin
						min_time_d = ram_rdata.tim;
						min_id_d   = ram_rdata.id;
						min_off_d  = pend_off_q;
						best_off   = pend_off_q;
					end
					if (pend_off_q == count_q - ONE) begin
						rd_off_d = best_off + ONE;
						state_d  = rqs_pkg::ENG_SHIFT;
					end
				end
			end
			rqs_pkg::ENG_SHIFT: begin
				if (rd_off_q < count_q) begin
					ram_re     = 1'b1;
					ram_raddr  = phys(head_q, rd_off_q);
					rd_off_d   = rd_off_q + ONE;
					pend_d     = 1'b1;
					pend_off_d = rd_off_q;
				end else begin
					pend_d = 1'b0;
				end
				if (pend_q) begin
					ram_we    = 1'b1;
					ram_waddr = phys(head_q, pend_off_q - ONE);
					ram_wdata = ram_rdata;
				end else if (rd_off_q >= count_q) begin
					res_push             = 1'b1;
					res.pick_valid       = 1'b1;
					res.picked_id        = min_id_q;
					res.picked_remaining = min_time_q;
					count_d              = count_q - ONE;
					state_d              = rqs_pkg::ENG_IDLE;
				end
			end
			default: begin
				state_d = rqs_pkg::ENG_IDLE;
			end
		endcase

		res.queue_count = count5(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rqs_pkg::ENG_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			run_id_q    <= 8'd0;
			run_valid_q <= 1'b0;
			rd_off_q    <= '0;
			pend_q      <= 1'b0;
		end else begin
			head_q      <= head_d;
			count_q     <= count_d;
			run_id_q    <= run_id_d;
			run_valid_q <= run_valid_d;
			rd_off_q    <= rd_off_d;
			pend_q      <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_off_q <= pend_off_d;
		min_time_q <= min_time_d;
		min_id_q   <= min_id_d;
		min_off_q  <= min_off_d;
		cur_q      <= cur_d;
	end

endmodule
